[hdl/rbsi_pkg.sv]
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared types and constants for the ray / box slab intersection block.
// ----------------------------------------------------------------------------
package rbsi_pkg;

  localparam int unsigned COORD_BITS   = 32;
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned DIST_BITS    = COORD_BITS - 1;
  localparam int unsigned FACE_BITS    = 3;
  localparam int unsigned REG_IDX_BITS = 3;

  // Configuration register indexes
  localparam logic [REG_IDX_BITS-1:0] REG_BOX_MIN_X = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_BOX_MIN_Y = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_BOX_MIN_Z = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_BOX_MAX_X = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_BOX_MAX_Y = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_BOX_MAX_Z = 3'd5;

  // Face codes
  localparam logic [FACE_BITS-1:0] FACE_NEG_X = 3'd0;
  localparam logic [FACE_BITS-1:0] FACE_POS_X = 3'd1;
  localparam logic [FACE_BITS-1:0] FACE_NEG_Y = 3'd2;
  localparam logic [FACE_BITS-1:0] FACE_POS_Y = 3'd3;
  localparam logic [FACE_BITS-1:0] FACE_NEG_Z = 3'd4;
  localparam logic [FACE_BITS-1:0] FACE_POS_Z = 3'd5;

  localparam logic [FACE_BITS-1:0] FACE_MIN [3] = '{FACE_NEG_X, FACE_NEG_Y, FACE_NEG_Z};
  localparam logic [FACE_BITS-1:0] FACE_MAX [3] = '{FACE_POS_X, FACE_POS_Y, FACE_POS_Z};

  typedef struct packed {
    logic signed [COORD_BITS-1:0] origin_x;
    logic signed [COORD_BITS-1:0] origin_y;
    logic signed [COORD_BITS-1:0] origin_z;
    logic signed [COORD_BITS-1:0] dir_x;
    logic signed [COORD_BITS-1:0] dir_y;
    logic signed [COORD_BITS-1:0] dir_z;
    logic [DIST_BITS-1:0]         best_distance;
  } rbsi_in_t;

  typedef struct packed {
    logic                         hit;
    logic [DIST_BITS-1:0]         hit_distance;
    logic signed [COORD_BITS-1:0] hit_point_x;
    logic signed [COORD_BITS-1:0] hit_point_y;
    logic signed [COORD_BITS-1:0] hit_point_z;
    logic [FACE_BITS-1:0]         face;
  } rbsi_out_t;

endpackage

[hdl/ray_box_slab_intersect.sv]
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// Pipelined ray versus axis-aligned box test (slab method), signed Q16.16.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake               payload
//  -------  ---------  ----------------------  -------------------------------
//  in       input      in_valid_i / in_stall_o  rbsi_in_t  (origin, dir, best)
//  out      output     out_valid_o / out_stall_i rbsi_out_t (hit, t, point, face)
//  cfg      input      cfg_we_i                 cfg_index_i, cfg_wdata_i
//
//  One item enters per cycle while the pipeline does not stall; each result
//  passes stage 1, stage 2, the divider stages and P1 to P6. The depth is set
//  mostly by the six slab dividers, which produce one quotient bit per stage.
//  Reset clears all valid bits and loads the unit box; no clearing pass.
//  Stall is global: the whole pipeline holds while the output item waits,
//  and in_stall_o is raised only in that case.
//
module ray_box_slab_intersect (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rbsi_pkg::REG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [rbsi_pkg::COORD_BITS-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  rbsi_pkg::rbsi_in_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output rbsi_pkg::rbsi_out_t                 out_item_o
);
  import rbsi_pkg::*;

  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned FB  = FRAC_BITS;
  localparam int unsigned OW  = 2 * CB - FB + 1;
  localparam int unsigned PW  = 2 * CB;
  localparam int unsigned SW  = 2 * CB + 1;

  localparam logic [CB-1:0] SAT_MAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic [CB-1:0] SAT_MIN = {1'b1, {(CB-1){1'b0}}};

  // per-item context carried alongside the arithmetic
  typedef struct packed {
    logic [2:0][CB-1:0] org;
    logic [2:0][CB-1:0] dir;
    logic [DIST_BITS-1:0] best;
    logic               par_miss;
  } ctx_t;

  // one divider lane: remainder, shifting dividend/quotient, divisor, flags
  typedef struct packed {
    logic [CB-2:0] rem;
    logic [CB-1:0] qd;
    logic [CB-1:0] den;
    logic          neg;
    logic          ovf;
    logic          dz;
  } lane_t;

  // global advance: move everything when the output slot is free or taken
  logic adv;
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  // --------------------------------------------------------------------------
  // Box registers
  // --------------------------------------------------------------------------
  logic [2:0][CB-1:0] box_lo_q, box_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_lo_q <= '0;
      for (int a = 0; a < 3; a++) begin
        box_hi_q[a] <= CB'(1) << FB;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_BOX_MIN_X: box_lo_q[0] <= cfg_wdata_i;
        REG_BOX_MIN_Y: box_lo_q[1] <= cfg_wdata_i;
        REG_BOX_MIN_Z: box_lo_q[2] <= cfg_wdata_i;
        REG_BOX_MAX_X: box_hi_q[0] <= cfg_wdata_i;
        REG_BOX_MAX_Y: box_hi_q[1] <= cfg_wdata_i;
        REG_BOX_MAX_Z: box_hi_q[2] <= cfg_wdata_i;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: plane minus origin for all six slab planes, parallel check
  // Lane 2a is the min plane of axis a, lane 2a+1 the max plane.
  // --------------------------------------------------------------------------
  ctx_t              s1_ctx_d, s1_ctx_q;
  logic [5:0][CB:0]  s1_diff_d, s1_diff_q;
  logic              s1_v_q;

  always_comb begin
    logic [CB-1:0] plane;
    s1_ctx_d.org[0]  = in_item_i.origin_x;
    s1_ctx_d.org[1]  = in_item_i.origin_y;
    s1_ctx_d.org[2]  = in_item_i.origin_z;
    s1_ctx_d.dir[0]  = in_item_i.dir_x;
    s1_ctx_d.dir[1]  = in_item_i.dir_y;
    s1_ctx_d.dir[2]  = in_item_i.dir_z;
    s1_ctx_d.best    = in_item_i.best_distance;
    s1_ctx_d.par_miss = 1'b0;
    for (int a = 0; a < 3; a++) begin
      if (s1_ctx_d.dir[a] == '0 &&
          ($signed(s1_ctx_d.org[a]) < $signed(box_lo_q[a]) ||
           $signed(s1_ctx_d.org[a]) > $signed(box_hi_q[a]))) begin
        s1_ctx_d.par_miss = 1'b1;
      end
    end
    for (int l = 0; l < 6; l++) begin
      plane = (l % 2 == 0) ? box_lo_q[l / 2] : box_hi_q[l / 2];
      s1_diff_d[l] = {plane[CB-1], plane} -
                     {s1_ctx_d.org[l / 2][CB-1], s1_ctx_d.org[l / 2]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ctx_q  <= s1_ctx_d;
      s1_diff_q <= s1_diff_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: magnitudes, quotient sign, overflow test, divider seed
  // --------------------------------------------------------------------------
  lane_t [5:0] lane_q [0:CB];
  ctx_t        ctx_q  [0:CB];
  logic        dv_q   [0:CB];
  lane_t [5:0] s2_lane_d;

  always_comb begin
    logic [CB:0]   mag;
    logic [CB-1:0] dir;
    logic [CB-1:0] dmag;
    for (int l = 0; l < 6; l++) begin
      dir  = s1_ctx_q.dir[l / 2];
      mag  = s1_diff_q[l][CB] ? (~s1_diff_q[l] + 1'b1) : s1_diff_q[l];
      dmag = dir[CB-1] ? (~dir + 1'b1) : dir;
      s2_lane_d[l].den = dmag;
      s2_lane_d[l].neg = s1_diff_q[l][CB] ^ dir[CB-1];
      s2_lane_d[l].dz  = (dir == '0);
      // quotient reaches 2^CB or more: saturate later
      s2_lane_d[l].ovf = OW'(mag) >= (OW'(dmag) << (CB - FB));
      // top bits of the dividend already sit below the divisor
      s2_lane_d[l].rem = (CB-1)'(mag[CB:CB-FB]);
      s2_lane_d[l].qd  = {mag[CB-FB-1:0], {FB{1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (adv) begin
      dv_q[0] <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lane_q[0] <= s2_lane_d;
      ctx_q[0]  <= s1_ctx_q;
    end
  end

  // --------------------------------------------------------------------------
  // Divider pipeline: one restoring step per stage, six lanes side by side
  // --------------------------------------------------------------------------
  for (genvar k = 1; k <= CB; k++) begin : g_div
    lane_t [5:0] nxt;

    always_comb begin
      logic [CB-1:0] tmp;
      logic [CB-1:0] sub;
      logic          ge;
      for (int l = 0; l < 6; l++) begin
        tmp = {lane_q[k-1][l].rem, lane_q[k-1][l].qd[CB-1]};
        sub = tmp - lane_q[k-1][l].den;
        ge  = tmp >= lane_q[k-1][l].den;
        nxt[l]     = lane_q[k-1][l];
        nxt[l].rem = ge ? sub[CB-2:0] : tmp[CB-2:0];
        nxt[l].qd  = {lane_q[k-1][l].qd[CB-2:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else if (adv) begin
        dv_q[k] <= dv_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        lane_q[k] <= nxt;
        ctx_q[k]  <= ctx_q[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // P1: apply sign and saturate each slab distance
  // --------------------------------------------------------------------------
  logic [5:0][CB-1:0] p1_t_d, p1_t_q;
  ctx_t               p1_ctx_q;
  logic               p1_v_q;

  always_comb begin
    lane_t ln;
    for (int l = 0; l < 6; l++) begin
      ln = lane_q[CB][l];
      if (ln.dz) begin
        p1_t_d[l] = (l % 2 == 0) ? SAT_MIN : SAT_MAX;
      end else if (ln.neg) begin
        p1_t_d[l] = (ln.ovf || (ln.qd[CB-1] && |ln.qd[CB-2:0])) ? SAT_MIN
                                                                : (~ln.qd + 1'b1);
      end else begin
        p1_t_d[l] = (ln.ovf || ln.qd[CB-1]) ? SAT_MAX : ln.qd;
      end
    end
  end

  // --------------------------------------------------------------------------
  // P2: order each axis into entry and exit
  // --------------------------------------------------------------------------
  logic [2:0][CB-1:0]        p2_ent_d, p2_ext_d, p2_ent_q, p2_ext_q;
  logic [2:0][FACE_BITS-1:0] p2_fen_d, p2_fex_d, p2_fen_q, p2_fex_q;
  ctx_t                      p2_ctx_q;
  logic                      p2_v_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if ($signed(p1_t_q[2*a]) > $signed(p1_t_q[2*a+1])) begin
        p2_ent_d[a] = p1_t_q[2*a+1];
        p2_ext_d[a] = p1_t_q[2*a];
        p2_fen_d[a] = FACE_MAX[a];
        p2_fex_d[a] = FACE_MIN[a];
      end else begin
        p2_ent_d[a] = p1_t_q[2*a];
        p2_ext_d[a] = p1_t_q[2*a+1];
        p2_fen_d[a] = FACE_MIN[a];
        p2_fex_d[a] = FACE_MAX[a];
      end
    end
  end

  // --------------------------------------------------------------------------
  // P3: latest entry and earliest exit, later axis wins ties
  // --------------------------------------------------------------------------
  logic [CB-1:0]        p3_near_d, p3_far_d, p3_near_q, p3_far_q;
  logic [FACE_BITS-1:0] p3_fn_d, p3_ff_d, p3_fn_q, p3_ff_q;
  logic                 p3_miss_d, p3_miss_q;
  ctx_t                 p3_ctx_q;
  logic                 p3_v_q;

  always_comb begin
    p3_near_d = p2_ent_q[0];
    p3_fn_d   = p2_fen_q[0];
    p3_far_d  = p2_ext_q[0];
    p3_ff_d   = p2_fex_q[0];
    for (int a = 1; a < 3; a++) begin
      if ($signed(p2_ent_q[a]) >= $signed(p3_near_d)) begin
        p3_near_d = p2_ent_q[a];
        p3_fn_d   = p2_fen_q[a];
      end
      if ($signed(p2_ext_q[a]) <= $signed(p3_far_d)) begin
        p3_far_d = p2_ext_q[a];
        p3_ff_d  = p2_fex_q[a];
      end
    end
    p3_miss_d = p2_ctx_q.par_miss || ($signed(p3_far_d) < $signed(p3_near_d));
  end

  // --------------------------------------------------------------------------
  // P4: pick entry or exit (origin inside), range check against best
  // --------------------------------------------------------------------------
  logic [CB-1:0]        p4_t_d, p4_t_q;
  logic [FACE_BITS-1:0] p4_face_d, p4_face_q;
  logic                 p4_hit_d, p4_hit_q;
  ctx_t                 p4_ctx_q;
  logic                 p4_v_q;

  always_comb begin
    if ($signed(p3_near_q) < 0) begin
      p4_t_d    = p3_far_q;
      p4_face_d = p3_ff_q;
    end else begin
      p4_t_d    = p3_near_q;
      p4_face_d = p3_fn_q;
    end
    p4_hit_d = !p3_miss_q && ($signed(p4_t_d) > 0) &&
               ($signed(p4_t_d) <= $signed({1'b0, p3_ctx_q.best}));
  end

  // --------------------------------------------------------------------------
  // P5: t times direction, one multiplier per axis
  // --------------------------------------------------------------------------
  logic [2:0][PW-1:0]   p5_prod_d, p5_prod_q;
  logic [CB-1:0]        p5_t_q;
  logic [FACE_BITS-1:0] p5_face_q;
  logic                 p5_hit_q;
  ctx_t                 p5_ctx_q;
  logic                 p5_v_q;

  always_comb begin
    logic signed [PW-1:0] prod;
    for (int a = 0; a < 3; a++) begin
      prod = $signed(p4_t_q) * $signed(p4_ctx_q.dir[a]);
      p5_prod_d[a] = prod;
    end
  end

  // --------------------------------------------------------------------------
  // P6: floor to Q16.16, add origin, saturate, form the output item
  // --------------------------------------------------------------------------
  rbsi_out_t out_d, out_q;
  logic      out_v_q;

  always_comb begin
    logic signed [PW-1:0] sh;
    logic [SW-1:0]        sum;
    logic [2:0][CB-1:0]   pt;
    for (int a = 0; a < 3; a++) begin
      sh  = $signed(p5_prod_q[a]) >>> FB;
      sum = {sh[PW-1], sh} +
            {{(SW-CB){p5_ctx_q.org[a][CB-1]}}, p5_ctx_q.org[a]};
      if ((&sum[SW-1:CB-1]) || !(|sum[SW-1:CB-1])) begin
        pt[a] = sum[CB-1:0];
      end else begin
        pt[a] = sum[SW-1] ? SAT_MIN : SAT_MAX;
      end
    end
    out_d = '0;
    if (p5_hit_q) begin
      out_d.hit          = 1'b1;
      out_d.hit_distance = p5_t_q[CB-2:0];
      out_d.hit_point_x  = pt[0];
      out_d.hit_point_y  = pt[1];
      out_d.hit_point_z  = pt[2];
      out_d.face         = p5_face_q;
    end
  end

  // post-divider valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q  <= 1'b0;
      p2_v_q  <= 1'b0;
      p3_v_q  <= 1'b0;
      p4_v_q  <= 1'b0;
      p5_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      p1_v_q  <= dv_q[CB];
      p2_v_q  <= p1_v_q;
      p3_v_q  <= p2_v_q;
      p4_v_q  <= p3_v_q;
      p5_v_q  <= p4_v_q;
      out_v_q <= p5_v_q;
    end
  end

  // post-divider payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_t_q    <= p1_t_d;
      p1_ctx_q  <= ctx_q[CB];
      p2_ent_q  <= p2_ent_d;
      p2_ext_q  <= p2_ext_d;
      p2_fen_q  <= p2_fen_d;
      p2_fex_q  <= p2_fex_d;
      p2_ctx_q  <= p1_ctx_q;
      p3_near_q <= p3_near_d;
      p3_far_q  <= p3_far_d;
      p3_fn_q   <= p3_fn_d;
      p3_ff_q   <= p3_ff_d;
      p3_miss_q <= p3_miss_d;
      p3_ctx_q  <= p2_ctx_q;
      p4_t_q    <= p4_t_d;
      p4_face_q <= p4_face_d;
      p4_hit_q  <= p4_hit_d;
      p4_ctx_q  <= p3_ctx_q;
      p5_prod_q <= p5_prod_d;
      p5_t_q    <= p4_t_q;
      p5_face_q <= p4_face_q;
      p5_hit_q  <= p4_hit_q;
      p5_ctx_q  <= p4_ctx_q;
      out_q     <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule

[hdl/rbsi_checker.sv]
// ----------------------------------------------------------------------------
// rbsi_checker
// Port-level assertions for ray_box_slab_intersect, attached by bind.
// ----------------------------------------------------------------------------
module rbsi_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input rbsi_pkg::rbsi_in_t                in_item_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input rbsi_pkg::rbsi_out_t               out_item_o
);
  import rbsi_pkg::*;

  // a miss carries an all-zero payload
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.hit |->
      out_item_o.hit_distance == '0 && out_item_o.hit_point_x == '0 &&
      out_item_o.hit_point_y == '0 && out_item_o.hit_point_z == '0 &&
      out_item_o.face == FACE_NEG_X)
    else $error("miss item with nonzero payload");

  // a hit has a positive distance and a legal face
  a_hit_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.hit |->
      out_item_o.hit_distance != '0 && out_item_o.face <= FACE_POS_Z)
    else $error("hit item with zero distance or bad face");

  // input is held back only while the output item waits
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // a waiting output item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled output item changed");

  // a stalled input item holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_item_i))
    else $error("stalled input item changed");

endmodule

bind ray_box_slab_intersect rbsi_checker u_rbsi_checker (.*);
